[design/assert_macros.svh]
// Assertion macros shared by the SCGI parser RTL.
// No dependencies; the bodies drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset
`define SCGI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define SCGI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCGI_ASSERT(lbl, clk, rst, prop, msg)
`define SCGI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[design/scgi_pkg.sv]
// Types, codes and header match tables for the SCGI request byte parser.
// No dependencies; used by scgi_core and the top level.
package scgi_pkg;

  localparam int LEN_BITS_DEF = 32;

  // Parser phases
  typedef enum logic [2:0] {
    PH_LEN    = 3'd0,
    PH_HSTART = 3'd1,
    PH_HNAME  = 3'd2,
    PH_HVALUE = 3'd3,
    PH_BODY   = 3'd4,
    PH_GOOD   = 3'd5,
    PH_BAD    = 3'd6
  } phase_t;

  // Result status codes
  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_GOOD    = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  // Byte kind codes
  localparam logic [2:0] KIND_FRAME = 3'd0;
  localparam logic [2:0] KIND_NAME  = 3'd1;
  localparam logic [2:0] KIND_VALUE = 3'd2;
  localparam logic [2:0] KIND_URI   = 3'd3;
  localparam logic [2:0] KIND_BODY  = 3'd4;

  // Method codes
  localparam logic [1:0] METH_NONE = 2'd0;
  localparam logic [1:0] METH_GET  = 2'd1;
  localparam logic [1:0] METH_PUT  = 2'd2;
  localparam logic [1:0] METH_POST = 2'd3;

  // Framing characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Header names in match order: content length, SCGI, request method, request URI
  localparam logic [127:0] HDR_NAME [4] = '{
    128'({"CONTENT", "_LENGTH"}), 128'("SCGI"),
    128'({"REQUEST", "_METHOD"}), 128'({"REQUEST", "_URI"})
  };
  localparam logic [3:0] HDR_LEN [4] = '{4'd14, 4'd4, 4'd14, 4'd11};

  // Value words: "1" (for SCGI), GET, PUT, POST
  localparam logic [31:0] VAL_WORD [4] = '{32'("1"), 32'("GET"), 32'("PUT"), 32'("POST")};
  localparam logic [3:0] VAL_LEN [4] = '{4'd1, 4'd3, 4'd3, 4'd4};

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  byte_value;
    logic [2:0]  byte_kind;
    logic [1:0]  method_code;
    logic [31:0] body_length;
  } res_t;

  // Drop header candidates that have no character at pos or whose character at pos differs from b
  function automatic logic [3:0] name_step(logic [3:0] flags, logic [3:0] pos, logic [7:0] b);
    logic [3:0] r;
    logic [3:0] k;
    r = flags;
    for (int i = 0; i < 4; i++) begin
      k = HDR_LEN[i] - 4'd1 - pos;
      if (!(pos < HDR_LEN[i]) || (HDR_NAME[i][{k, 3'b000} +: 8] != b)) begin
        r[i] = 1'b0;
      end
    end
    return r;
  endfunction

  // Keep header candidates whose length equals pos
  function automatic logic [3:0] name_end(logic [3:0] flags, logic [3:0] pos);
    logic [3:0] r;
    r = flags;
    for (int i = 0; i < 4; i++) begin
      if (pos != HDR_LEN[i]) begin
        r[i] = 1'b0;
      end
    end
    return r;
  endfunction

  // Drop value word candidates that have no character at pos or whose character at pos differs from b
  function automatic logic [3:0] val_step(logic [3:0] flags, logic [3:0] pos, logic [7:0] b);
    logic [3:0] r;
    logic [3:0] k;
    r = flags;
    for (int i = 0; i < 4; i++) begin
      k = VAL_LEN[i] - 4'd1 - pos;
      if (!(pos < VAL_LEN[i]) || (VAL_WORD[i][{k[1:0], 3'b000} +: 8] != b)) begin
        r[i] = 1'b0;
      end
    end
    return r;
  endfunction

  // Keep value word candidates whose length equals pos
  function automatic logic [3:0] val_end(logic [3:0] flags, logic [3:0] pos);
    logic [3:0] r;
    r = flags;
    for (int i = 0; i < 4; i++) begin
      if (pos != VAL_LEN[i]) begin
        r[i] = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

[design/scgi_if.sv]
// Valid/ready channel interfaces for the SCGI parser request and result streams.
// No dependencies.
interface scgi_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, req_type, data_byte, input ready);
  modport sink (input valid, req_type, data_byte, output ready);
endinterface

interface scgi_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  byte_value;
  logic [2:0]  byte_kind;
  logic [1:0]  method_code;
  logic [31:0] body_length;

  modport source (output valid, status, byte_value, byte_kind, method_code, body_length,
                  input ready);
  modport sink (input valid, status, byte_value, byte_kind, method_code, body_length,
                output ready);
endinterface

[design/scgi_core.sv]
// Parser state and per-byte next-state logic for the SCGI request parser.
// Depends on scgi_pkg for phases, codes and header match tables.
module scgi_core import scgi_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  req_t req,
  output res_t res
);

  localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);

  phase_t              phase, phase_next;
  logic [LEN_BITS-1:0] ns_size, ns_size_next;
  logic [LEN_BITS-1:0] ns_seen, ns_seen_next;
  logic                len_digit, len_digit_next;
  logic [3:0]          name_pos, name_pos_next;
  logic [3:0]          name_flags, name_flags_next;
  logic [3:0]          val_pos, val_pos_next;
  logic [3:0]          val_flags, val_flags_next;
  logic [31:0]         val_num, val_num_next;
  logic                val_num_ok, val_num_ok_next;
  logic [1:0]          hdr_count, hdr_count_next;
  logic [31:0]         content_size, content_size_next;
  logic [31:0]         body_seen, body_seen_next;
  logic [1:0]          method, method_next;

  logic [7:0]          b;
  logic                is_digit;
  logic [LEN_BITS-1:0] remaining;
  logic [LEN_BITS+3:0] ns_ext;
  logic                ns_over;
  logic [35:0]         val_ext;
  logic                val_over;
  logic [3:0]          vf_end;
  logic                hdr_ok;
  logic [31:0]         body_inc;
  logic [2:0]          kind;

  // Shared decode of the current byte
  always_comb begin
    b         = req.data_byte;
    is_digit  = b inside {[8'h30:8'h39]};
    remaining = ns_size - ns_seen;
    ns_ext    = ({4'b0, ns_size} << 3) + ({4'b0, ns_size} << 1) + (LEN_BITS + 4)'(b[3:0]);
    ns_over   = |ns_ext[LEN_BITS+3:LEN_BITS];
    val_ext   = ({4'b0, val_num} << 3) + ({4'b0, val_num} << 1) + 36'(b[3:0]);
    val_over  = |val_ext[35:32];
    vf_end    = val_end(val_flags, val_pos);
    body_inc  = body_seen + 32'd1;
    case (hdr_count)
      2'd0:    hdr_ok = name_flags[0] && val_num_ok && (val_pos != 4'd0);
      2'd1:    hdr_ok = name_flags[1] && vf_end[0];
      default: hdr_ok = 1'b1;
    endcase
  end

  // Next state for one byte
  always_comb begin
    phase_next        = phase;
    ns_size_next      = ns_size;
    ns_seen_next      = ns_seen;
    len_digit_next    = len_digit;
    name_pos_next     = name_pos;
    name_flags_next   = name_flags;
    val_pos_next      = val_pos;
    val_flags_next    = val_flags;
    val_num_next      = val_num;
    val_num_ok_next   = val_num_ok;
    hdr_count_next    = hdr_count;
    content_size_next = content_size;
    body_seen_next    = body_seen;
    method_next       = method;
    kind              = KIND_FRAME;

    if (req.req_type) begin
      // Restart: return everything to its reset value
      phase_next        = PH_LEN;
      ns_size_next      = '0;
      ns_seen_next      = '0;
      len_digit_next    = 1'b0;
      name_pos_next     = 4'd0;
      name_flags_next   = 4'hF;
      val_pos_next      = 4'd0;
      val_flags_next    = 4'hF;
      val_num_next      = 32'd0;
      val_num_ok_next   = 1'b0;
      hdr_count_next    = 2'd0;
      content_size_next = 32'd0;
      body_seen_next    = 32'd0;
      method_next       = METH_NONE;
    end else begin
      case (phase)
        PH_LEN: begin
          if (is_digit) begin
            if (ns_over) begin
              phase_next = PH_BAD;
            end else begin
              ns_size_next   = ns_ext[LEN_BITS-1:0];
              len_digit_next = 1'b1;
            end
          end else if (b == CH_COLON && len_digit) begin
            ns_seen_next    = '0;
            name_pos_next   = 4'd0;
            name_flags_next = 4'hF;
            phase_next      = PH_HSTART;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_HSTART, PH_HNAME: begin
          if (phase == PH_HSTART && b == CH_COMMA) begin
            // End of netstring: length must match exactly
            if (remaining == '0) begin
              phase_next = (content_size != 32'd0) ? PH_BODY : PH_GOOD;
            end else begin
              phase_next = PH_BAD;
            end
          end else if (remaining > LEN_ONE) begin
            ns_seen_next = ns_seen + LEN_ONE;
            if (b == CH_NUL) begin
              if (name_pos == 4'd0) begin
                phase_next = PH_BAD;
              end else begin
                name_flags_next = name_end(name_flags, name_pos);
                val_pos_next    = 4'd0;
                val_flags_next  = 4'hF;
                val_num_next    = 32'd0;
                val_num_ok_next = 1'b1;
                phase_next      = PH_HVALUE;
              end
            end else begin
              name_flags_next = name_step(name_flags, name_pos, b);
              if (name_pos != 4'd15) begin
                name_pos_next = name_pos + 4'd1;
              end
              phase_next = PH_HNAME;
              kind       = KIND_NAME;
            end
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_HVALUE: begin
          if (remaining != '0) begin
            ns_seen_next = ns_seen + LEN_ONE;
            if (b == CH_NUL) begin
              // Close the header pair and check the required ones
              if (hdr_ok) begin
                if (hdr_count == 2'd0) begin
                  content_size_next = val_num;
                end
                if (name_flags[2]) begin
                  if (vf_end[1]) begin
                    method_next = METH_GET;
                  end else if (vf_end[2]) begin
                    method_next = METH_PUT;
                  end else if (vf_end[3]) begin
                    method_next = METH_POST;
                  end
                end
                if (hdr_count != 2'd2) begin
                  hdr_count_next = hdr_count + 2'd1;
                end
                name_pos_next   = 4'd0;
                name_flags_next = 4'hF;
                phase_next      = PH_HSTART;
              end else begin
                phase_next = PH_BAD;
              end
            end else begin
              kind = name_flags[3] ? KIND_URI : KIND_VALUE;
              if (val_num_ok) begin
                if (!is_digit || val_over) begin
                  val_num_ok_next = 1'b0;
                end else begin
                  val_num_next = val_ext[31:0];
                end
              end
              val_flags_next = val_step(val_flags, val_pos, b);
              if (val_pos != 4'd15) begin
                val_pos_next = val_pos + 4'd1;
              end
            end
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_BODY: begin
          kind           = KIND_BODY;
          body_seen_next = body_inc;
          if (body_inc == content_size) begin
            phase_next = PH_GOOD;
          end
        end
        PH_GOOD: begin
          phase_next = PH_GOOD;
        end
        default: begin
          phase_next = PH_BAD;
        end
      endcase
    end

    // Result reflects the state after this byte
    case (phase_next)
      PH_GOOD: res.status = ST_GOOD;
      PH_BAD:  res.status = ST_BAD;
      default: res.status = ST_PENDING;
    endcase
    res.byte_value  = b;
    res.byte_kind   = kind;
    res.method_code = method_next;
    res.body_length = content_size_next;
  end

  // Advance the parser state on each transfer into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEN;
      ns_size      <= '0;
      ns_seen      <= '0;
      len_digit    <= 1'b0;
      name_pos     <= 4'd0;
      name_flags   <= 4'hF;
      val_pos      <= 4'd0;
      val_flags    <= 4'hF;
      val_num      <= 32'd0;
      val_num_ok   <= 1'b0;
      hdr_count    <= 2'd0;
      content_size <= 32'd0;
      body_seen    <= 32'd0;
      method       <= METH_NONE;
    end else if (step) begin
      phase        <= phase_next;
      ns_size      <= ns_size_next;
      ns_seen      <= ns_seen_next;
      len_digit    <= len_digit_next;
      name_pos     <= name_pos_next;
      name_flags   <= name_flags_next;
      val_pos      <= val_pos_next;
      val_flags    <= val_flags_next;
      val_num      <= val_num_next;
      val_num_ok   <= val_num_ok_next;
      hdr_count    <= hdr_count_next;
      content_size <= content_size_next;
      body_seen    <= body_seen_next;
      method       <= method_next;
    end
  end

endmodule

[design/scgi_request_byte_parser.sv]
// Top level of the SCGI request byte parser: input register, parser core, result register.
// Depends on scgi_pkg, scgi_if.sv, scgi_core and assert_macros.svh.
//
//   channel  dir  transfer when          payload
//   req      in   req.valid & req.ready  req_type, data_byte
//   res      out  res.valid & res.ready  status, byte_value, byte_kind, method_code, body_length
//
// One byte per cycle sustained while results are accepted: the parser core is a single pass between two registers.
// A byte's result is presented once the byte moves from the input register into the result
// register; the parser state updates as the byte enters the result register.
// rst (synchronous) empties both registers and returns the parser to the length phase.
// A stalled result holds the input register, which in turn drops req.ready; a byte may
// still enter an empty input register while a result waits.
`include "assert_macros.svh"

module scgi_request_byte_parser import scgi_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  scgi_req_if.sink  req,
  scgi_res_if.source res
);

  logic s1_valid;
  req_t s1_req;
  logic step;
  res_t core_res;
  logic res_valid;
  res_t res_q;

  // Move a byte into the result stage when that stage is free or draining
  assign step      = s1_valid && (!res_valid || res.ready);
  assign req.ready = !s1_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_req <= '{req_type: req.req_type, data_byte: req.data_byte};
    end
  end

  scgi_core #(
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .req  (s1_req),
    .res  (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= core_res;
    end
  end

  assign res.valid       = res_valid;
  assign res.status      = res_q.status;
  assign res.byte_value  = res_q.byte_value;
  assign res.byte_kind   = res_q.byte_kind;
  assign res.method_code = res_q.method_code;
  assign res.body_length = res_q.body_length;

  // Checks
  `SCGI_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !res.valid, "result valid after reset")
  `SCGI_ASSERT(a_in_taken, clk, rst, (req.valid && req.ready) |=> s1_valid,
               "input transfer lost")
  `SCGI_ASSERT(a_bad_frame, clk, rst,
               (res.valid && res.status == ST_BAD) |-> (res.byte_kind == KIND_FRAME),
               "rejecting byte not framing")
  `SCGI_ASSERT(a_hdr_pending, clk, rst,
               (res.valid && (res.byte_kind == KIND_NAME || res.byte_kind == KIND_VALUE ||
                res.byte_kind == KIND_URI)) |-> (res.status == ST_PENDING),
               "header byte with final status")

endmodule
